FILE: hdl/bpe_pkg.sv
// Shared types and constants for the Bezier profile point evaluator.
// Used by every module under hdl/; depends on nothing else.
package bpe_pkg;

    // Curve parameter one in Q1.16
    localparam logic [16:0] T_ONE = 17'h10000;

    // Degree register codes
    localparam logic [1:0] DEG_LINEAR = 2'd0;
    localparam logic [1:0] DEG_QUAD   = 2'd1;
    localparam logic [1:0] DEG_CUBIC  = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_DEGREE       = 3'd0;
    localparam logic [2:0] CFG_CTRL1_R      = 3'd1;
    localparam logic [2:0] CFG_CTRL1_Z      = 3'd2;
    localparam logic [2:0] CFG_CTRL2_R      = 3'd3;
    localparam logic [2:0] CFG_CTRL2_Z      = 3'd4;
    localparam logic [2:0] CFG_RADIUS_END   = 3'd5;
    localparam logic [2:0] CFG_RADIUS_START = 3'd6;
    localparam logic [2:0] CFG_FULL_LENGTH  = 3'd7;

    // Configuration register file as seen by the pipeline
    typedef struct packed {
        logic        [1:0]  degree;
        logic signed [15:0] ctrl1_r;
        logic signed [15:0] ctrl1_z;
        logic signed [15:0] ctrl2_r;
        logic signed [15:0] ctrl2_z;
        logic        [23:0] radius_end;
        logic        [23:0] radius_start;
        logic        [23:0] full_length;
    } t_cfg;

endpackage

FILE: hdl/bezier_profile_point_eval.sv
// Bezier profile point evaluator, top level: config registers, input stage, pipeline.
// Depends on bpe_pkg, bpe_weight, bpe_blend and bpe_map.
// Pipeline: an accepted beat passes 7 register stages (stage 0 to stage 6) on its way to o_valid.
// Throughput: one beat per cycle; the whole pipeline holds while the output beat is stalled.
// Reset: valid bits clear and all config registers return to 0 (linear, zero radii and length).
module bezier_profile_point_eval (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // parameter input channel
    input  logic               i_valid,
    input  logic [16:0]        i_t_frac,
    output logic               o_stall,
    // result channel
    output logic               o_valid,
    output logic signed [31:0] o_radius,
    output logic signed [31:0] o_height,
    input  logic               i_stall,
    // config write channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data
);

    bpe_pkg::t_cfg      r_cfg;

    logic               w_en;
    logic [16:0]        w_tc;

    logic               r_v0;
    logic [16:0]        r_t;
    logic [16:0]        r_u;
    logic [1:0]         r_deg;

    logic               w_v2;
    logic [32:0]        w_w1;
    logic [32:0]        w_w2;
    logic [32:0]        w_w3;
    logic               w_v4;
    logic signed [37:0] w_bx;
    logic signed [37:0] w_by;

    // Advance every stage unless the output beat is held
    assign w_en        = !(o_valid && i_stall);
    assign o_stall     = !w_en;
    assign o_cfg_ready = 1'b1;

    // Config register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                bpe_pkg::CFG_DEGREE:       r_cfg.degree       <= i_cfg_data[1:0];
                bpe_pkg::CFG_CTRL1_R:      r_cfg.ctrl1_r      <= $signed(i_cfg_data[15:0]);
                bpe_pkg::CFG_CTRL1_Z:      r_cfg.ctrl1_z      <= $signed(i_cfg_data[15:0]);
                bpe_pkg::CFG_CTRL2_R:      r_cfg.ctrl2_r      <= $signed(i_cfg_data[15:0]);
                bpe_pkg::CFG_CTRL2_Z:      r_cfg.ctrl2_z      <= $signed(i_cfg_data[15:0]);
                bpe_pkg::CFG_RADIUS_END:   r_cfg.radius_end   <= i_cfg_data;
                bpe_pkg::CFG_RADIUS_START: r_cfg.radius_start <= i_cfg_data;
                bpe_pkg::CFG_FULL_LENGTH:  r_cfg.full_length  <= i_cfg_data;
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // Stage 0: clamp t to one and form u = 1 - t
    assign w_tc = (i_t_frac > bpe_pkg::T_ONE) ? bpe_pkg::T_ONE : i_t_frac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_en) begin
            r_v0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t   <= w_tc;
            r_u   <= bpe_pkg::T_ONE - w_tc;
            r_deg <= r_cfg.degree;
        end
    end

    bpe_weight u_weight (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (r_v0),
        .i_t      (r_t),
        .i_u      (r_u),
        .i_degree (r_deg),
        .o_valid  (w_v2),
        .o_w1     (w_w1),
        .o_w2     (w_w2),
        .o_w3     (w_w3)
    );

    bpe_blend u_blend (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_cfg    (r_cfg),
        .i_valid  (w_v2),
        .i_w1     (w_w1),
        .i_w2     (w_w2),
        .i_w3     (w_w3),
        .o_valid  (w_v4),
        .o_bx     (w_bx),
        .o_by     (w_by)
    );

    bpe_map u_map (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_cfg    (r_cfg),
        .i_valid  (w_v4),
        .i_bx     (w_bx),
        .i_by     (w_by),
        .o_valid  (o_valid),
        .o_radius (o_radius),
        .o_height (o_height)
    );

endmodule

FILE: hdl/bpe_weight.sv
// Bernstein weight stages: products of t and u, then Q1.32 weights per degree.
// Depends on bpe_pkg.
module bpe_weight (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [16:0]        i_t,
    input  logic [16:0]        i_u,
    input  logic [1:0]         i_degree,
    output logic               o_valid,
    output logic [32:0]        o_w1,
    output logic [32:0]        o_w2,
    output logic [32:0]        o_w3
);

    logic        r_v1;
    logic [33:0] r_tt;
    logic [33:0] r_ut;
    logic [33:0] r_uu;
    logic [16:0] r_t;
    logic [1:0]  r_deg;

    logic        r_v2;
    logic [32:0] r_w1;
    logic [32:0] r_w2;
    logic [32:0] r_w3;

    logic [49:0] w_p1;
    logic [49:0] w_p2;
    logic [49:0] w_p3;
    logic [51:0] w_s1;
    logic [51:0] w_s2;
    logic [51:0] w_s3;
    logic [32:0] n_w1;
    logic [32:0] n_w2;
    logic [32:0] n_w3;

    // Stage 1: square and cross products of t and u
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tt  <= {17'd0, i_t} * {17'd0, i_t};
            r_ut  <= {17'd0, i_u} * {17'd0, i_t};
            r_uu  <= {17'd0, i_u} * {17'd0, i_u};
            r_t   <= i_t;
            r_deg <= i_degree;
        end
    end

    // Stage 2: cubic triple products, the first two times three, rounded from Q48 to Q32
    assign w_p1 = {17'd0, r_uu[32:0]} * {33'd0, r_t};
    assign w_p2 = {17'd0, r_ut[32:0]} * {33'd0, r_t};
    assign w_p3 = {17'd0, r_tt[32:0]} * {33'd0, r_t};
    assign w_s1 = {2'b0, w_p1} + {1'b0, w_p1, 1'b0} + 52'h8000;
    assign w_s2 = {2'b0, w_p2} + {1'b0, w_p2, 1'b0} + 52'h8000;
    assign w_s3 = {2'b0, w_p3} + 52'h8000;

    // Select weights by curve form; the unused code gives the start point
    always_comb begin
        n_w1 = 33'd0;
        n_w2 = 33'd0;
        n_w3 = 33'd0;
        case (r_deg)
            bpe_pkg::DEG_LINEAR: begin
                n_w3 = {r_t, 16'd0};
            end
            bpe_pkg::DEG_QUAD: begin
                n_w1 = {r_ut[31:0], 1'b0};
                n_w3 = r_tt[32:0];
            end
            bpe_pkg::DEG_CUBIC: begin
                n_w1 = w_s1[48:16];
                n_w2 = w_s2[48:16];
                n_w3 = w_s3[48:16];
            end
            default: begin
                n_w1 = 33'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w1 <= n_w1;
            r_w2 <= n_w2;
            r_w3 <= n_w3;
        end
    end

    assign o_valid = r_v2;
    assign o_w1    = r_w1;
    assign o_w2    = r_w2;
    assign o_w3    = r_w3;

endmodule

FILE: hdl/bpe_blend.sv
// Control point blend stages: weighted control coordinates summed into B (Q32).
// Depends on bpe_pkg.
module bpe_blend (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  bpe_pkg::t_cfg       i_cfg,
    input  logic                i_valid,
    input  logic [32:0]         i_w1,
    input  logic [32:0]         i_w2,
    input  logic [32:0]         i_w3,
    output logic                o_valid,
    output logic signed [37:0]  o_bx,
    output logic signed [37:0]  o_by
);

    logic               r_v3;
    logic signed [49:0] r_px1;
    logic signed [49:0] r_px2;
    logic signed [49:0] r_pz1;
    logic signed [49:0] r_pz2;
    logic [32:0]        r_w3;

    logic               r_v4;
    logic signed [37:0] r_bx;
    logic signed [37:0] r_by;

    logic signed [51:0] w_sx;
    logic signed [51:0] w_sz;
    logic signed [41:0] w_bx;
    logic signed [41:0] w_by;

    // Stage 3: weight times control coordinate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v3 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px1 <= 50'($signed({1'b0, i_w1})) * 50'($signed(i_cfg.ctrl1_r));
            r_px2 <= 50'($signed({1'b0, i_w2})) * 50'($signed(i_cfg.ctrl2_r));
            r_pz1 <= 50'($signed({1'b0, i_w1})) * 50'($signed(i_cfg.ctrl1_z));
            r_pz2 <= 50'($signed({1'b0, i_w2})) * 50'($signed(i_cfg.ctrl2_z));
            r_w3  <= i_w3;
        end
    end

    // Stage 4: round Q44 to Q32, end point weight adds in exactly
    assign w_sx = 52'(r_px1) + 52'(r_px2) + 52'sd2048;
    assign w_sz = 52'(r_pz1) + 52'(r_pz2) + 52'sd2048;
    assign w_bx = 42'(w_sx >>> 12) + $signed({9'd0, r_w3});
    assign w_by = 42'(w_sz >>> 12) + $signed({9'd0, r_w3});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_bx <= w_bx[37:0];
            r_by <= w_by[37:0];
        end
    end

    assign o_valid = r_v4;
    assign o_bx    = r_bx;
    assign o_by    = r_by;

endmodule

FILE: hdl/bpe_map.sv
// Mapping stages: relative point scaled onto radius and height, then saturated.
// Depends on bpe_pkg.
module bpe_map (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  bpe_pkg::t_cfg       i_cfg,
    input  logic                i_valid,
    input  logic signed [37:0]  i_bx,
    input  logic signed [37:0]  i_by,
    output logic                o_valid,
    output logic signed [31:0]  o_radius,
    output logic signed [31:0]  o_height
);

    logic               r_v5;
    logic signed [62:0] r_mr;
    logic signed [62:0] r_mh;

    logic               r_v6;
    logic signed [31:0] r_radius;
    logic signed [31:0] r_height;

    logic signed [24:0] w_dr;
    logic signed [64:0] w_sr;
    logic signed [64:0] w_sh;
    logic signed [32:0] w_qr;
    logic signed [32:0] w_qh;

    // Clamp a 33-bit value to the signed 32-bit range
    function automatic logic [31:0] sat33(input logic signed [32:0] v);
        logic [31:0] res;
        if (v[32] != v[31]) begin
            res = v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    // Stage 5: scale B by radius span and by full length
    assign w_dr = $signed({1'b0, i_cfg.radius_end}) - $signed({1'b0, i_cfg.radius_start});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (i_en) begin
            r_v5 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mr <= 63'(i_bx) * 63'(w_dr);
            r_mh <= 63'(i_by) * 63'($signed({1'b0, i_cfg.full_length}));
        end
    end

    // Stage 6: add offsets, round Q32 to integer, saturate
    assign w_sr = $signed({9'd0, i_cfg.radius_start, 32'd0}) + 65'(r_mr)
                  + 65'sh0_8000_0000;
    assign w_sh = 65'(r_mh) - $signed({10'd0, i_cfg.full_length, 31'd0})
                  + 65'sh0_8000_0000;
    assign w_qr = 33'(w_sr >>> 32);
    assign w_qh = 33'(w_sh >>> 32);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else if (i_en) begin
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_radius <= sat33(w_qr);
            r_height <= sat33(w_qh);
        end
    end

    assign o_valid  = r_v6;
    assign o_radius = r_radius;
    assign o_height = r_height;

endmodule
